// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic clock and reset
`define ASSERT_CLKD(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// default clk_i / rst_ni
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLKD(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== src/bece_pkg.sv =====
// ----------------------------------------------------------------------------
// bece_pkg
// Shared constants, types and number-format helpers of the easing evaluator.
// ----------------------------------------------------------------------------
package bece_pkg;

  localparam int FRAC_BITS = 16;
  localparam int MAX_STEPS = 24;

  localparam int FX_W    = FRAC_BITS + 1;
  localparam int ACC_W   = FX_W + 3;
  localparam int STEP_W  = $clog2(MAX_STEPS + 1);
  localparam int TIME_W  = 18;
  localparam int Q16_W   = 17;
  localparam int CFG_W   = 7;
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [FX_W-1:0]  ONE_FX  = FX_W'(1) << FRAC_BITS;
  localparam logic [FX_W-1:0]  HALF_T  = FX_W'(1) << (FRAC_BITS - 1);
  localparam logic [Q16_W-1:0] Q16_ONE = Q16_W'(65536);

  localparam int UP_SH = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int DN_SH = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
  localparam int YW    = FX_W + DN_SH + 1;

  localparam int TOL_RAW = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam int TOL     = (TOL_RAW > 0) ? TOL_RAW : 1;

  localparam int CTRL_DIV  = 127;
  localparam int CTRL_HALF = 63;
  localparam int CTRL_QUO  = (1 << FRAC_BITS) / CTRL_DIV;
  localparam int CTRL_REM  = (1 << FRAC_BITS) % CTRL_DIV;
  localparam int CTRL_RW   = $clog2(CTRL_DIV * CTRL_REM + CTRL_HALF + 1);

  typedef enum logic [1:0] {
    REG_CTRL1_X = 2'd0,
    REG_CTRL1_Y = 2'd1,
    REG_CTRL2_X = 2'd2,
    REG_CTRL2_Y = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0] ctrl1_x;
    logic [CFG_W-1:0] ctrl1_y;
    logic [CFG_W-1:0] ctrl2_x;
    logic [CFG_W-1:0] ctrl2_y;
  } cfg_t;

  typedef struct packed {
    logic [FX_W-1:0] a;
    logic [FX_W-1:0] b;
  } mul_req_t;

  // v/127 in Q1.F, rounded half up: v*QUO plus a small remainder quotient
  function automatic logic [FX_W-1:0] ctrl_to_fx(input logic [CFG_W-1:0] v);
    logic [CTRL_RW-1:0] r;
    logic [FX_W-1:0]    q;
    int                 k;
    r = CTRL_RW'(v) * CTRL_RW'(CTRL_REM) + CTRL_RW'(CTRL_HALF);
    q = FX_W'(v) * FX_W'(CTRL_QUO);
    for (k = 1; k <= CTRL_REM; k++) begin
      if (r >= CTRL_RW'(k * CTRL_DIV)) begin
        q = q + FX_W'(1);
      end
    end
    return q;
  endfunction

  function automatic logic [FX_W-1:0] time_to_fx(input logic [TIME_W-1:0] raw);
    logic [Q16_W-1:0] tq;
    if (raw[TIME_W-1]) begin
      tq = '0;
    end else if (raw[Q16_W-1:0] > Q16_ONE) begin
      tq = Q16_ONE;
    end else begin
      tq = raw[Q16_W-1:0];
    end
    if (FRAC_BITS >= 16) begin
      return FX_W'(tq) << UP_SH;
    end else begin
      return FX_W'(tq >> DN_SH);
    end
  endfunction

  function automatic logic [Q16_W-1:0] y_to_q16(input logic [FX_W-1:0] y);
    logic [YW-1:0] w;
    w = (YW'(y) << DN_SH) + YW'((1 << UP_SH) >> 1);
    w = w >> UP_SH;
    if (w > YW'(Q16_ONE)) begin
      return Q16_ONE;
    end else begin
      return w[Q16_W-1:0];
    end
  endfunction

endpackage

// ===== src/bece_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bece_cfg_regs
// APB register file holding the two inner control points.
// ----------------------------------------------------------------------------
module bece_cfg_regs import bece_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_CTRL1_X: cfg_d.ctrl1_x = pwdata[CFG_W-1:0];
        REG_CTRL1_Y: cfg_d.ctrl1_y = pwdata[CFG_W-1:0];
        REG_CTRL2_X: cfg_d.ctrl2_x = pwdata[CFG_W-1:0];
        REG_CTRL2_Y: cfg_d.ctrl2_y = pwdata[CFG_W-1:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_CTRL1_X: prdata = PDATA_W'(cfg_q.ctrl1_x);
      REG_CTRL1_Y: prdata = PDATA_W'(cfg_q.ctrl1_y);
      REG_CTRL2_X: prdata = PDATA_W'(cfg_q.ctrl2_x);
      REG_CTRL2_Y: prdata = PDATA_W'(cfg_q.ctrl2_y);
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ctrl1_x <= CFG_W'(0);
      cfg_q.ctrl1_y <= CFG_W'(0);
      cfg_q.ctrl2_x <= CFG_W'(127);
      cfg_q.ctrl2_y <= CFG_W'(127);
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== src/bece_mul_unit.sv =====
// ----------------------------------------------------------------------------
// bece_mul_unit
// Shared Q1.F multiplier with round-half-up and a registered product.
// ----------------------------------------------------------------------------
module bece_mul_unit import bece_pkg::*; (
  input  logic            clk_i,
  input  mul_req_t        req_i,
  output logic [FX_W-1:0] prod_o
);

  logic [2*FX_W-1:0] full;
  logic [2*FX_W-1:0] rnd;
  logic [FX_W-1:0]   prod_q, prod_d;

  assign full   = (2*FX_W)'(req_i.a) * (2*FX_W)'(req_i.b);
  assign rnd    = full + (2*FX_W)'(HALF_T);
  assign prod_d = rnd[FRAC_BITS +: FX_W];
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

endmodule

// ===== src/bece_seq.sv =====
// ----------------------------------------------------------------------------
// bece_seq
// Sequencer: bisection on t, curve evaluation through the shared multiplier.
// ----------------------------------------------------------------------------
module bece_seq import bece_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [TIME_W-1:0] time_in_i,
  input  cfg_t              cfg_i,
  output mul_req_t          mul_req_o,
  input  logic [FX_W-1:0]   prod_i,
  output logic              done_o,
  output logic [Q16_W-1:0]  eased_value_o,
  output logic              converged_o
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_XEVAL = 3'b010,
    S_YEVAL = 3'b100
  } state_e;

  // one multiply a cycle; OP_SUM closes the evaluation
  localparam logic [3:0] OP_IT_IT = 4'd0;
  localparam logic [3:0] OP_X_T1  = 4'd1;
  localparam logic [3:0] OP_X_PA  = 4'd2;
  localparam logic [3:0] OP_IT_T  = 4'd3;
  localparam logic [3:0] OP_X_T2  = 4'd4;
  localparam logic [3:0] OP_X_PB  = 4'd5;
  localparam logic [3:0] OP_T_T   = 4'd6;
  localparam logic [3:0] OP_X_T3  = 4'd7;
  localparam logic [3:0] OP_SUM   = 4'd8;

  state_e            state_q, state_d;
  logic [3:0]        op_q, op_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;
  logic              conv_q, conv_d;

  logic [FX_W-1:0]   time_q, time_d;
  logic [FX_W-1:0]   lo_q, lo_d;
  logic [FX_W-1:0]   hi_q, hi_d;
  logic [FX_W-1:0]   t_q, t_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [Q16_W-1:0]  eased_q, eased_d;
  logic              conv_out_q, conv_out_d;

  logic [FX_W-1:0]   it;
  logic [FX_W-1:0]   pa, pb;
  logic [ACC_W-1:0]  prod3;
  logic [ACC_W-1:0]  sum;
  logic [FX_W-1:0]   x;
  logic [FX_W-1:0]   diff;
  logic              in_tol;
  logic              above;
  logic [FX_W-1:0]   lo_n, hi_n;
  logic [FX_W:0]     mid;
  logic              y_mode;

  assign y_mode = (state_q == S_YEVAL);
  assign it     = ONE_FX - t_q;
  assign pa     = y_mode ? ctrl_to_fx(cfg_i.ctrl1_y) : ctrl_to_fx(cfg_i.ctrl1_x);
  assign pb     = y_mode ? ctrl_to_fx(cfg_i.ctrl2_y) : ctrl_to_fx(cfg_i.ctrl2_x);

  assign prod3  = (ACC_W'(prod_i) << 1) + ACC_W'(prod_i);
  assign sum    = acc_q + ACC_W'(prod_i);
  assign x      = (sum > ACC_W'(ONE_FX)) ? ONE_FX : sum[FX_W-1:0];
  assign diff   = (time_q >= x) ? time_q - x : x - time_q;
  assign in_tol = (diff <= FX_W'(TOL));
  assign above  = (x > time_q);
  assign lo_n   = above ? lo_q : t_q;
  assign hi_n   = above ? t_q : hi_q;
  assign mid    = (FX_W+1)'(lo_n) + (FX_W+1)'(hi_n);

  assign busy_o        = (state_q != S_IDLE);
  assign done_o        = done_q;
  assign eased_value_o = eased_q;
  assign converged_o   = conv_out_q;

  always_comb begin
    unique case (op_q)
      OP_IT_IT: begin mul_req_o.a = it;     mul_req_o.b = it; end
      OP_X_T1:  begin mul_req_o.a = prod_i; mul_req_o.b = t_q; end
      OP_X_PA:  begin mul_req_o.a = prod_i; mul_req_o.b = pa; end
      OP_IT_T:  begin mul_req_o.a = it;     mul_req_o.b = t_q; end
      OP_X_T2:  begin mul_req_o.a = prod_i; mul_req_o.b = t_q; end
      OP_X_PB:  begin mul_req_o.a = prod_i; mul_req_o.b = pb; end
      OP_T_T:   begin mul_req_o.a = t_q;    mul_req_o.b = t_q; end
      OP_X_T3:  begin mul_req_o.a = prod_i; mul_req_o.b = t_q; end
      default:  begin mul_req_o.a = t_q;    mul_req_o.b = t_q; end
    endcase
  end

  always_comb begin
    unique case (op_q)
      OP_IT_IT:        acc_d = '0;
      OP_IT_T, OP_T_T: acc_d = acc_q + prod3;
      default:         acc_d = acc_q;
    endcase
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    step_d     = step_q;
    done_d     = 1'b0;
    conv_d     = conv_q;
    time_d     = time_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    t_d        = t_q;
    eased_d    = eased_q;
    conv_out_d = conv_out_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          state_d = S_XEVAL;
          op_d    = OP_IT_IT;
          step_d  = '0;
          time_d  = time_to_fx(time_in_i);
          lo_d    = '0;
          hi_d    = ONE_FX;
          t_d     = ONE_FX >> 1;
        end
      end
      S_XEVAL: begin
        if (op_q == OP_SUM) begin
          op_d = OP_IT_IT;
          if (in_tol) begin
            conv_d  = 1'b1;
            state_d = S_YEVAL;
          end else begin
            lo_d = lo_n;
            hi_d = hi_n;
            t_d  = mid[FX_W:1];
            if (step_q == STEP_W'(MAX_STEPS - 1)) begin
              conv_d  = 1'b0;
              state_d = S_YEVAL;
            end else begin
              step_d = step_q + STEP_W'(1);
            end
          end
        end else begin
          op_d = op_q + 4'd1;
        end
      end
      S_YEVAL: begin
        if (op_q == OP_SUM) begin
          done_d     = 1'b1;
          eased_d    = y_to_q16(x);
          conv_out_d = conv_q;
          state_d    = S_IDLE;
        end else begin
          op_d = op_q + 4'd1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_IT_IT;
      step_q  <= '0;
      done_q  <= 1'b0;
      conv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      step_q  <= step_d;
      done_q  <= done_d;
      conv_q  <= conv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    time_q     <= time_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    t_q        <= t_d;
    acc_q      <= acc_d;
    eased_q    <= eased_d;
    conv_out_q <= conv_out_d;
  end

endmodule

// ===== src/bezier_easing_curve_eval_unit.sv =====
// ----------------------------------------------------------------------------
// bezier_easing_curve_eval_unit
// Cubic Bezier easing: solves x(t) = time by bisection, returns y(t).
// ----------------------------------------------------------------------------
// Usage:
//   Control points are written over the APB port (registers at byte offsets
//   0, 4, 8, 12: ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, 7 bits each) while idle.
//   A time beat is taken on the edge where start is high and busy is low.
//   busy stays high until the result appears; done_o then marks
//   eased_value_o and converged_o for exactly one cycle.
// Sequencing:
//   Each curve evaluation runs on the single shared multiplier as eight
//   chained products plus the sum. With n bisection steps (1 to 24) the
//   result strobe follows n evaluations in x and one in y after the
//   accepting edge; busy drops in the strobe cycle, so the next beat can
//   be taken on the edge that ends it.
// Reset:
//   rst_ni clears the sequencer to idle and loads the linear default
//   control points (0,0) and (1,1).
// The receiver cannot stall: done_o is a one-cycle pulse.
// ----------------------------------------------------------------------------
module bezier_easing_curve_eval_unit import bece_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [TIME_W-1:0]  time_in_i,
  output logic               done_o,
  output logic [Q16_W-1:0]   eased_value_o,
  output logic               converged_o
);

  cfg_t            cfg;
  mul_req_t        mul_req;
  logic [FX_W-1:0] prod;

  bece_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bece_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  bece_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .time_in_i     (time_in_i),
    .cfg_i         (cfg),
    .mul_req_o     (mul_req),
    .prod_i        (prod),
    .done_o        (done_o),
    .eased_value_o (eased_value_o),
    .converged_o   (converged_o)
  );

endmodule

// ===== src/bece_checker.sv =====
// ----------------------------------------------------------------------------
// bece_checker
// Port-level checks on the easing evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bece_checker import bece_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input logic [Q16_W-1:0] eased_value_o
);

  `ASSERT_STD(a_start_busy, (start && !busy) |=> busy, "beat taken but not busy")
  `ASSERT_STD(a_done_idle, done_o |-> !busy, "result while still busy")
  `ASSERT_STD(a_fell_done, $fell(busy) |-> done_o, "busy dropped without result")
  `ASSERT_STD(a_done_pulse, done_o |=> !done_o, "result strobe longer than a cycle")
  `ASSERT_STD(a_range, done_o |-> (eased_value_o <= Q16_ONE), "eased value above one")

endmodule

bind bezier_easing_curve_eval_unit bece_checker u_bece_checker (.*);
